// ===== hw/rtl/tra_pkg.sv =====
// Shared types, constants and helper functions for the three-register execute block.
// Used by tra_muldiv, tra_alu and the top level under hw/rtl; depends on nothing else.
package tra_pkg;

    localparam int REG_COUNT = 13;
    localparam int SEL_W     = 4;
    localparam int XLEN      = 64;
    localparam int PC_W      = 32;
    localparam int IN_W      = 96;
    localparam int OUT_W     = 104;

    localparam logic [XLEN-1:0] SIGN64    = 64'h8000_0000_0000_0000;
    localparam logic [XLEN-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [XLEN-1:0] HIGH_WORD = 64'hFFFF_FFFF_0000_0000;

    typedef enum logic [5:0] {
        CMD_ADD_32   = 6'd0,
        CMD_SUB_32   = 6'd1,
        CMD_MUL_32   = 6'd2,
        CMD_DIVU_32  = 6'd3,
        CMD_DIV_32   = 6'd4,
        CMD_REMU_32  = 6'd5,
        CMD_REM_32   = 6'd6,
        CMD_SLL_32   = 6'd7,
        CMD_SRL_32   = 6'd8,
        CMD_SRA_32   = 6'd9,
        CMD_ADD_64   = 6'd10,
        CMD_SUB_64   = 6'd11,
        CMD_MUL_64   = 6'd12,
        CMD_DIVU_64  = 6'd13,
        CMD_DIV_64   = 6'd14,
        CMD_REMU_64  = 6'd15,
        CMD_REM_64   = 6'd16,
        CMD_SLL_64   = 6'd17,
        CMD_SRL_64   = 6'd18,
        CMD_SRA_64   = 6'd19,
        CMD_AND      = 6'd20,
        CMD_XOR      = 6'd21,
        CMD_OR       = 6'd22,
        CMD_MULH     = 6'd23,
        CMD_MULHU    = 6'd24,
        CMD_MULHSU   = 6'd25,
        CMD_SLTU     = 6'd26,
        CMD_SLT      = 6'd27,
        CMD_CMOV_Z   = 6'd28,
        CMD_CMOV_NZ  = 6'd29,
        CMD_ROL_64   = 6'd30,
        CMD_ROL_32   = 6'd31,
        CMD_ROR_64   = 6'd32,
        CMD_ROR_32   = 6'd33,
        CMD_AND_INV  = 6'd34,
        CMD_OR_INV   = 6'd35,
        CMD_XNOR     = 6'd36,
        CMD_MAX      = 6'd37,
        CMD_MAX_U    = 6'd38,
        CMD_MIN      = 6'd39,
        CMD_MIN_U    = 6'd40,
        CMD_LOAD_IMM = 6'd41
    } cmd_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_status_t;

    function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [XLEN-1:0] mag64(input logic [XLEN-1:0] v);
        return v[XLEN-1] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [SEL_W-1:0] clamp_sel(input logic [7:0] s);
        return (s > 8'(REG_COUNT - 1)) ? SEL_W'(REG_COUNT - 1) : s[SEL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tra_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tra_muldiv.sv =====
// Shared bit-serial unit: 64x64 unsigned multiply or 64/64 unsigned divide, one bit a cycle.
// Depends on tra_pkg.
module tra_muldiv
    import tra_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  md_req_t         req,
    input  logic [XLEN-1:0] op_a,
    input  logic [XLEN-1:0] op_b,
    output md_status_t      status,
    output logic [XLEN-1:0] res_lo,
    output logic [XLEN-1:0] res_hi
);

    logic [2*XLEN-1:0] acc_reg;
    logic [XLEN-1:0]   divisor_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              div_reg;
    logic              done_reg;
    logic [XLEN:0]     mul_sum;
    logic [XLEN:0]     partial;
    logic [XLEN+1:0]   diff;
    logic              fits;
    logic [2*XLEN-1:0] acc_next;

    always_comb
    begin
        mul_sum  = {1'b0, acc_reg[2*XLEN-1:XLEN]} + (acc_reg[0] ? {1'b0, divisor_reg} : '0);
        partial  = acc_reg[2*XLEN-1:XLEN-1];
        diff     = {1'b0, partial} - {2'b00, divisor_reg};
        fits     = !diff[XLEN+1];
        if (div_reg)
        begin
            acc_next = {(fits ? diff[XLEN-1:0] : partial[XLEN-1:0]), acc_reg[XLEN-2:0], fits};
        end
        else
        begin
            acc_next = {mul_sum, acc_reg[XLEN-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                div_reg     <= req.is_div;
                acc_reg     <= {{XLEN{1'b0}}, op_a};
                divisor_reg <= op_b;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign res_lo      = acc_reg[XLEN-1:0];
    assign res_hi      = acc_reg[2*XLEN-1:XLEN];

endmodule

// ===== hw/rtl/tra_alu.sv =====
// Result selection for all operations, including sign fix-up of the serial unit's output.
// Depends on tra_pkg.
module tra_alu
    import tra_pkg::*;
(
    input  logic [5:0]      cmd,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    input  logic [XLEN-1:0] imm,
    input  logic [XLEN-1:0] md_lo,
    input  logic [XLEN-1:0] md_hi,
    output logic [XLEN-1:0] result,
    output logic            wr
);

    logic              w32;
    logic              div32;
    logic [XLEN-1:0]   da;
    logic [XLEN-1:0]   db;
    logic              bzero;
    logic              ovf;
    logic [XLEN-1:0]   div_res;
    logic [XLEN-1:0]   rem_res;
    logic [5:0]        s6;
    logic [4:0]        s5;
    logic [5:0]        ns6;
    logic [4:0]        ns5;
    logic [2*XLEN-1:0] rol64_w;
    logic [2*XLEN-1:0] ror64_w;
    logic [XLEN-1:0]   rol32_w;
    logic [XLEN-1:0]   ror32_w;
    logic              lt_s;
    logic              lt_u;

    always_comb
    begin
        w32     = (cmd == CMD_DIV_32) || (cmd == CMD_REM_32);
        div32   = cmd inside {CMD_DIVU_32, CMD_DIV_32, CMD_REMU_32, CMD_REM_32};
        da      = w32 ? sx32(a) : a;
        db      = w32 ? sx32(b) : b;
        bzero   = div32 ? (b[31:0] == 32'd0) : (b == '0);
        ovf     = (da == SIGN64) && (db == ALL_ONES);
        div_res = bzero ? ALL_ONES : (ovf ? da : ((da[XLEN-1] ^ db[XLEN-1]) ? -md_lo : md_lo));
        rem_res = bzero ? da : (ovf ? '0 : (da[XLEN-1] ? -md_hi : md_hi));
        s6      = b[5:0];
        s5      = b[4:0];
        ns6     = 6'(7'd64 - {1'b0, s6});
        ns5     = 5'(6'd32 - {1'b0, s5});
        rol64_w = {a, a} << s6;
        ror64_w = {a, a} << ns6;
        rol32_w = {a[31:0], a[31:0]} << s5;
        ror32_w = {a[31:0], a[31:0]} << ns5;
        lt_s    = $signed(a) < $signed(b);
        lt_u    = a < b;

        wr     = 1'b1;
        result = '0;
        case (cmd)
            CMD_ADD_32:   result = sx32(64'(a[31:0] + b[31:0]));
            CMD_SUB_32:   result = sx32(64'(a[31:0] - b[31:0]));
            CMD_MUL_32:   result = sx32(md_lo);
            CMD_DIVU_32:  result = sx32(bzero ? ALL_ONES : md_lo);
            CMD_DIV_32:   result = sx32(div_res);
            CMD_REMU_32:  result = sx32(bzero ? a : md_hi);
            CMD_REM_32:   result = sx32(rem_res);
            CMD_SLL_32:   result = sx32(64'(a[31:0]) << s5);
            CMD_SRL_32:   result = sx32(64'(a[31:0]) >> s5);
            CMD_SRA_32:   result = 64'($signed(sx32(a)) >>> s5);
            CMD_ADD_64:   result = a + b;
            CMD_SUB_64:   result = a - b;
            CMD_MUL_64:   result = md_lo;
            CMD_DIVU_64:  result = bzero ? ALL_ONES : md_lo;
            CMD_DIV_64:   result = div_res;
            CMD_REMU_64:  result = bzero ? a : md_hi;
            CMD_REM_64:   result = rem_res;
            CMD_SLL_64:   result = a << s6;
            CMD_SRL_64:   result = a >> s6;
            CMD_SRA_64:   result = 64'($signed(a) >>> s6);
            CMD_AND:      result = a & b;
            CMD_XOR:      result = a ^ b;
            CMD_OR:       result = a | b;
            CMD_MULH:     result = md_hi - (a[XLEN-1] ? b : '0) - (b[XLEN-1] ? a : '0);
            CMD_MULHU:    result = md_hi;
            CMD_MULHSU:   result = md_hi - (a[XLEN-1] ? b : '0);
            CMD_SLTU:     result = 64'(lt_u);
            CMD_SLT:      result = 64'(lt_s);
            CMD_CMOV_Z:
            begin
                wr     = (b == '0);
                result = a;
            end
            CMD_CMOV_NZ:
            begin
                wr     = (b != '0);
                result = a;
            end
            CMD_ROL_64:   result = rol64_w[2*XLEN-1:XLEN];
            CMD_ROL_32:   result = sx32({32'd0, rol32_w[XLEN-1:32]});
            CMD_ROR_64:   result = ror64_w[2*XLEN-1:XLEN];
            CMD_ROR_32:   result = sx32({32'd0, ror32_w[XLEN-1:32]});
            CMD_AND_INV:  result = a & ~b;
            CMD_OR_INV:   result = a | ~b;
            CMD_XNOR:     result = ~(a ^ b);
            CMD_MAX:      result = lt_s ? b : a;
            CMD_MAX_U:    result = lt_u ? b : a;
            CMD_MIN:      result = lt_s ? a : b;
            CMD_MIN_U:    result = lt_u ? a : b;
            CMD_LOAD_IMM: result = imm;
            default:      wr = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/three_register_alu_execute.sv =====
// Top level of the three-register execute block: sequencer, register file and output stage.
// Depends on tra_pkg, tra_ram, tra_muldiv and tra_alu.
//
//   Channel   Direction  Payload
//   s_axis    in         cmd, src_a_sel, src_b_sel, dest_sel, operand_length, load_value
//   m_axis    out        wrote, dest_index, dest_value, next_pc
//
// An instruction makes three reads of the single register file port
// (first source, second source, old destination), then write-back.
// Multiply, divide and remainder also pass through the one-bit-a-cycle serial unit.
// Reset clears the state, the program counter and the valid bits that make unwritten
// registers read as zero. A new instruction is taken while a result still waits;
// write-back stalls until the output register is free.
module three_register_alu_execute
    import tra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[5:0], src_a_sel[9:6], src_b_sel[13:10], dest_sel[21:14],
    // operand_length[26:22], load_value[90:27], zero fill above
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // wrote[0], dest_index[4:1], dest_value[68:5], next_pc[100:69], zero fill above
    output logic [OUT_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_D,
        ST_MD,
        ST_WB
    } state_t;

    state_t                state_reg;
    logic [5:0]            cmd_reg;
    logic [SEL_W-1:0]      ib_reg;
    logic [SEL_W-1:0]      id_reg;
    logic [4:0]            len_reg;
    logic [XLEN-1:0]       imm_reg;
    logic [XLEN-1:0]       a_reg;
    logic [XLEN-1:0]       b_reg;
    logic [XLEN-1:0]       d_reg;
    logic [PC_W-1:0]       pc_reg;
    logic [PC_W-1:0]       pc_next;
    logic [REG_COUNT-1:0]  valid_reg;
    logic                  rvalid_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    md_req_t               md_req_reg;
    md_status_t            md_st;

    logic [SEL_W-1:0]      ram_raddr;
    logic [XLEN-1:0]       ram_rdata;
    logic [XLEN-1:0]       rd_value;
    logic                  ram_we;
    logic                  out_free;
    logic                  accept;
    logic                  md_op;
    logic                  div_op;
    logic [XLEN-1:0]       md_a;
    logic [XLEN-1:0]       md_b;
    logic [XLEN-1:0]       md_lo;
    logic [XLEN-1:0]       md_hi;
    logic [XLEN-1:0]       alu_result;
    logic                  alu_wr;
    logic [XLEN-1:0]       dest_value;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign ram_we        = (state_reg == ST_WB) && out_free && alu_wr;
    assign rd_value      = rvalid_reg ? ram_rdata : '0;
    assign dest_value    = alu_wr ? alu_result : d_reg;
    assign pc_next       = pc_reg + 32'd1 + 32'(len_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        case (state_reg)
            ST_RD_A: ram_raddr = ib_reg;
            ST_RD_B: ram_raddr = id_reg;
            default: ram_raddr = clamp_sel(8'(s_axis_tdata[9:6]));
        endcase
    end

    always_comb
    begin
        md_op  = cmd_reg inside {CMD_MUL_32, CMD_DIVU_32, CMD_DIV_32, CMD_REMU_32, CMD_REM_32,
                                 CMD_MUL_64, CMD_DIVU_64, CMD_DIV_64, CMD_REMU_64, CMD_REM_64,
                                 CMD_MULH, CMD_MULHU, CMD_MULHSU};
        div_op = cmd_reg inside {CMD_DIVU_32, CMD_DIV_32, CMD_REMU_32, CMD_REM_32,
                                 CMD_DIVU_64, CMD_DIV_64, CMD_REMU_64, CMD_REM_64};
        case (cmd_reg)
            CMD_MUL_32, CMD_DIVU_32, CMD_REMU_32:
            begin
                md_a = {32'd0, a_reg[31:0]};
                md_b = {32'd0, b_reg[31:0]};
            end
            CMD_DIV_32, CMD_REM_32:
            begin
                md_a = mag64(sx32(a_reg));
                md_b = mag64(sx32(b_reg));
            end
            CMD_DIV_64, CMD_REM_64:
            begin
                md_a = mag64(a_reg);
                md_b = mag64(b_reg);
            end
            default:
            begin
                md_a = a_reg;
                md_b = b_reg;
            end
        endcase
    end

    tra_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata (alu_result),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tra_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req_reg),
        .op_a   (md_a),
        .op_b   (md_b),
        .status (md_st),
        .res_lo (md_lo),
        .res_hi (md_hi)
    );

    tra_alu u_alu (
        .cmd    (cmd_reg),
        .a      (a_reg),
        .b      (b_reg),
        .imm    (imm_reg),
        .md_lo  (md_lo),
        .md_hi  (md_hi),
        .result (alu_result),
        .wr     (alu_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            md_req_reg    <= '0;
        end
        else
        begin
            rvalid_reg <= valid_reg[ram_raddr];
            if (m_axis_tready && (state_reg != ST_WB))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= s_axis_tdata[5:0];
                        ib_reg    <= clamp_sel(8'(s_axis_tdata[13:10]));
                        id_reg    <= clamp_sel(s_axis_tdata[21:14]);
                        len_reg   <= s_axis_tdata[26:22];
                        imm_reg   <= s_axis_tdata[90:27];
                        state_reg <= ST_RD_A;
                    end
                end
                ST_RD_A:
                begin
                    a_reg     <= rd_value;
                    state_reg <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    b_reg     <= rd_value;
                    state_reg <= ST_RD_D;
                end
                ST_RD_D:
                begin
                    d_reg <= rd_value;
                    if (md_op)
                    begin
                        md_req_reg.start  <= 1'b1;
                        md_req_reg.is_div <= div_op;
                        state_reg         <= ST_MD;
                    end
                    else
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_MD:
                begin
                    md_req_reg.start <= 1'b0;
                    if (md_st.done)
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (out_free)
                    begin
                        if (alu_wr)
                        begin
                            valid_reg[id_reg] <= 1'b1;
                        end
                        pc_reg        <= pc_next;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, pc_next, dest_value, id_reg, alu_wr};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) s_axis_tready |-> !md_st.busy)
        else $error("Instruction taken while the serial unit is busy.");

    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> (state_reg == ST_WB))
        else $error("Register file written outside write-back.");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (state_reg == ST_RD_A))
        else $error("Accepted transfer did not start a register read.");

    assert property (@(posedge clk) disable iff (!rst_n) md_st.done |-> (state_reg == ST_MD))
        else $error("Serial unit finished while not awaited.");

endmodule
